### sv/qau_pkg.sv
`default_nettype none

package qau_pkg;

   localparam int unsigned FRAC_BITS_DEF = 16;

   // One root bit per stage for the 64-bit sum of squares, one quotient bit
   // per stage in the dividers.
   localparam int unsigned SQ_N = 32;
   localparam int unsigned DV_N = 32;

   typedef logic signed [31:0] word_type;

   typedef enum logic [3:0] {
      ACT_ADD       = 4'd0,
      ACT_SUB       = 4'd1,
      ACT_SCALE     = 4'd2,
      ACT_MUL       = 4'd3,
      ACT_CONJ      = 4'd4,
      ACT_NORM      = 4'd5,
      ACT_NORMALIZE = 4'd6,
      ACT_INVERSE   = 4'd7,
      ACT_MATRIX    = 4'd8
   } action_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   localparam word_type WORD_MAX = 32'sh7fffffff;
   localparam word_type WORD_MIN = 32'sh80000000;
   localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
   localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

   typedef struct packed {
      logic [3:0]        action;
      word_type [3:0]    a;
      logic [15:0][63:0] p;
      word_type [3:0]    res;
      logic [1:0]        st;
   } s1_type;

   typedef struct packed {
      logic [3:0]        action;
      word_type [3:0]    a;
      logic [15:0][63:0] rp;
      word_type [3:0]    res;
      logic [1:0]        st;
      logic [63:0]       ssum;
   } s2_type;

   typedef struct packed {
      logic [3:0]       action;
      word_type [3:0]   res;
      logic [1:0]       st;
      word_type [8:0]   mat;
      logic [2:0]       mflag;
      logic [3:0][31:0] mag;
      logic [3:0]       neg;
      logic             szero;
      logic             n2zero;
      logic [63:0]      n2;
   } carry_type;

   typedef struct packed {
      carry_type   c;
      logic [63:0] rad;
      logic [34:0] rem;
      logic [31:0] root;
   } sq_type;

   typedef struct packed {
      carry_type        c;
      logic [63:0]      den;
      logic [3:0][65:0] rr;
      logic [3:0][31:0] nlo;
      logic [3:0][31:0] q;
      logic [3:0]       ovf;
   } dv_type;

   function automatic logic sat_hit(input logic signed [65:0] v);
      return (v > WIDE_MAX) || (v < WIDE_MIN);
   endfunction

   function automatic word_type sat_word(input logic signed [65:0] v);
      word_type r;
      if (v > WIDE_MAX) begin
         r = WORD_MAX;
      end else if (v < WIDE_MIN) begin
         r = WORD_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/qau_if.sv
`default_nettype none

interface qau_req_if import qau_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [3:0] action;
   word_type   a_w;
   word_type   a_x;
   word_type   a_y;
   word_type   a_z;
   word_type   b_w;
   word_type   b_x;
   word_type   b_y;
   word_type   b_z;
   word_type   scale;

   modport source (
      output valid, action, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale,
      input  ready
   );
   modport sink (
      input  valid, action, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale,
      output ready
   );
endinterface

interface qau_rsp_if import qau_pkg::*; ();
   logic       valid;
   logic       ready;
   word_type   out_w;
   word_type   out_x;
   word_type   out_y;
   word_type   out_z;
   logic [1:0] status;
   logic       last;

   modport source (
      output valid, out_w, out_x, out_y, out_z, status, last,
      input  ready
   );
   modport sink (
      input  valid, out_w, out_x, out_y, out_z, status, last,
      output ready
   );
endinterface

`default_nettype wire

### sv/quaternion_arithmetic_unit_core.sv
// Fixed-point quaternion unit. Each beat on req_chan carries an action, the
// quaternions a and b and a scale factor. Results leave on rsp_chan: one beat
// per item, or three row beats for the rotation matrix, the third with last.
// A beat is accepted when valid and ready are both high.
// The path runs through product, rounding and combining stages, a 32-stage
// square root (one root bit per stage), a division setup stage and a 32-stage
// divider with four lanes (one quotient bit per stage), then the output register.
// Every item takes the full path, so the order of results is the order of
// beats. Throughput is one item per cycle while the receiver does not stall; a
// matrix item holds the pipeline while its three rows leave, one row per ready cycle.
// When the receiver stalls the output register holds its beat and the whole
// pipeline freezes; req_chan.ready drops in the same cycle.
// Synchronous reset clears all stage valid bits and the row counter; data
// registers keep their contents.
`default_nettype none

module quaternion_arithmetic_unit_core import qau_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   qau_req_if.sink   req_chan,
   qau_rsp_if.source rsp_chan
);

   localparam logic signed [63:0] HALF  = 64'(1) << (FRAC_BITS - 1);
   localparam logic signed [65:0] ONE66 = 66'(1) << FRAC_BITS;

   logic adv;

   // Entry: operand selection, products, and the add, subtract and conjugate results.
   s1_type s1_in, s1_ff;
   logic   s1_vld_ff;
   word_type in_a [4];
   word_type in_b [4];
   word_type opa [16];
   word_type opb [16];
   logic signed [63:0] prod [16];
   logic signed [65:0] t1;
   logic hit1;

   always_comb begin
      in_a[0] = req_chan.a_w;
      in_a[1] = req_chan.a_x;
      in_a[2] = req_chan.a_y;
      in_a[3] = req_chan.a_z;
      in_b[0] = req_chan.b_w;
      in_b[1] = req_chan.b_x;
      in_b[2] = req_chan.b_y;
      in_b[3] = req_chan.b_z;
      for (int k = 0; k < 16; k++) begin
         opa[k] = '0;
         opb[k] = '0;
      end
      s1_in = '0;
      hit1 = 1'b0;
      t1 = '0;
      s1_in.action = req_chan.action;
      for (int i = 0; i < 4; i++) begin
         s1_in.a[i] = in_a[i];
      end
      case (req_chan.action)
         ACT_ADD: begin
            for (int i = 0; i < 4; i++) begin
               t1 = 66'(in_a[i]) + 66'(in_b[i]);
               s1_in.res[i] = sat_word(t1);
               hit1 = hit1 | sat_hit(t1);
            end
         end
         ACT_SUB: begin
            for (int i = 0; i < 4; i++) begin
               t1 = 66'(in_a[i]) - 66'(in_b[i]);
               s1_in.res[i] = sat_word(t1);
               hit1 = hit1 | sat_hit(t1);
            end
         end
         ACT_CONJ: begin
            s1_in.res[0] = in_a[0];
            for (int i = 1; i < 4; i++) begin
               t1 = -66'(in_a[i]);
               s1_in.res[i] = sat_word(t1);
               hit1 = hit1 | sat_hit(t1);
            end
         end
         ACT_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               opa[i] = in_a[i];
               opb[i] = req_chan.scale;
            end
         end
         ACT_MUL: begin
            for (int i = 0; i < 4; i++) begin
               for (int j = 0; j < 4; j++) begin
                  opa[i*4+j] = in_a[i];
                  opb[i*4+j] = in_b[j];
               end
            end
         end
         ACT_NORM, ACT_NORMALIZE, ACT_INVERSE, ACT_MATRIX: begin
            for (int i = 0; i < 4; i++) begin
               opa[i] = in_a[i];
               opb[i] = in_a[i];
            end
            opa[4] = in_a[1]; opb[4] = in_a[2];
            opa[5] = in_a[1]; opb[5] = in_a[3];
            opa[6] = in_a[2]; opb[6] = in_a[3];
            opa[7] = in_a[1]; opb[7] = in_a[0];
            opa[8] = in_a[2]; opb[8] = in_a[0];
            opa[9] = in_a[3]; opb[9] = in_a[0];
         end
         default: begin
         end
      endcase
      for (int k = 0; k < 16; k++) begin
         prod[k] = opa[k] * opb[k];
         s1_in.p[k] = prod[k];
      end
      s1_in.st = hit1 ? ST_SAT : ST_OK;
   end

   // Rounding of products and the sum of squares.
   s2_type s2_in, s2_ff;
   logic   s2_vld_ff;
   logic signed [63:0] rnd [16];
   logic [65:0] sq66;

   always_comb begin
      s2_in.action = s1_ff.action;
      s2_in.a      = s1_ff.a;
      s2_in.res    = s1_ff.res;
      s2_in.st     = s1_ff.st;
      for (int k = 0; k < 16; k++) begin
         rnd[k] = ($signed(s1_ff.p[k]) + HALF) >>> FRAC_BITS;
         s2_in.rp[k] = rnd[k];
      end
      sq66 = 66'(s1_ff.p[0]) + 66'(s1_ff.p[1]) + 66'(s1_ff.p[2]) + 66'(s1_ff.p[3]);
      s2_in.ssum = (sq66[65:64] != 2'b00) ? '1 : sq66[63:0];
   end

   // Combining: product sums, matrix entries and division operands.
   sq_type s3_in, s3_ff;
   logic   s3_vld_ff;
   logic signed [63:0] rpv [16];
   logic signed [65:0] mv [9];
   logic signed [65:0] t3;
   logic hit3;

   always_comb begin
      s3_in = '0;
      hit3 = 1'b0;
      t3 = '0;
      for (int k = 0; k < 16; k++) begin
         rpv[k] = $signed(s2_ff.rp[k]);
      end
      mv[0] = ONE66 - (66'(rpv[2]) <<< 1) - (66'(rpv[3]) <<< 1);
      mv[1] = (66'(rpv[4]) - 66'(rpv[9])) <<< 1;
      mv[2] = (66'(rpv[5]) + 66'(rpv[8])) <<< 1;
      mv[3] = (66'(rpv[4]) + 66'(rpv[9])) <<< 1;
      mv[4] = ONE66 - (66'(rpv[1]) <<< 1) - (66'(rpv[3]) <<< 1);
      mv[5] = (66'(rpv[6]) - 66'(rpv[7])) <<< 1;
      mv[6] = (66'(rpv[5]) - 66'(rpv[8])) <<< 1;
      mv[7] = (66'(rpv[6]) + 66'(rpv[7])) <<< 1;
      mv[8] = ONE66 - (66'(rpv[1]) <<< 1) - (66'(rpv[2]) <<< 1);
      s3_in.c.action = s2_ff.action;
      s3_in.c.res    = s2_ff.res;
      s3_in.c.st     = s2_ff.st;
      case (s2_ff.action)
         ACT_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               t3 = 66'(rpv[i]);
               s3_in.c.res[i] = sat_word(t3);
               hit3 = hit3 | sat_hit(t3);
            end
            s3_in.c.st = hit3 ? ST_SAT : ST_OK;
         end
         ACT_MUL: begin
            t3 = 66'(rpv[0]) - 66'(rpv[5]) - 66'(rpv[10]) - 66'(rpv[15]);
            s3_in.c.res[0] = sat_word(t3);
            hit3 = hit3 | sat_hit(t3);
            t3 = 66'(rpv[1]) + 66'(rpv[4]) + 66'(rpv[11]) - 66'(rpv[14]);
            s3_in.c.res[1] = sat_word(t3);
            hit3 = hit3 | sat_hit(t3);
            t3 = 66'(rpv[2]) + 66'(rpv[8]) + 66'(rpv[13]) - 66'(rpv[7]);
            s3_in.c.res[2] = sat_word(t3);
            hit3 = hit3 | sat_hit(t3);
            t3 = 66'(rpv[3]) + 66'(rpv[12]) + 66'(rpv[6]) - 66'(rpv[9]);
            s3_in.c.res[3] = sat_word(t3);
            hit3 = hit3 | sat_hit(t3);
            s3_in.c.st = hit3 ? ST_SAT : ST_OK;
         end
         ACT_MATRIX: begin
            for (int r = 0; r < 3; r++) begin
               for (int col = 0; col < 3; col++) begin
                  s3_in.c.mat[r*3+col] = sat_word(mv[r*3+col]);
                  s3_in.c.mflag[r] = s3_in.c.mflag[r] | sat_hit(mv[r*3+col]);
               end
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         s3_in.c.mag[i] = s2_ff.a[i][31] ? (~s2_ff.a[i] + 32'd1) : s2_ff.a[i];
         if (s2_ff.action == ACT_INVERSE && i != 0) begin
            s3_in.c.neg[i] = !s2_ff.a[i][31] && (s2_ff.a[i] != '0);
         end else begin
            s3_in.c.neg[i] = s2_ff.a[i][31];
         end
      end
      s3_in.c.n2     = s2_ff.ssum >> FRAC_BITS;
      s3_in.c.szero  = (s2_ff.ssum == '0);
      s3_in.c.n2zero = ((s2_ff.ssum >> FRAC_BITS) == '0);
      s3_in.rad      = s2_ff.ssum;
   end

   // Square root, two radicand bits per stage.
   function automatic sq_type sq_step(input sq_type s);
      sq_type      o;
      logic [34:0] rem2;
      logic [34:0] trial;
      o = s;
      rem2  = {s.rem[32:0], s.rad[63:62]};
      trial = {1'b0, s.root, 2'b01};
      if (rem2 >= trial) begin
         o.rem  = rem2 - trial;
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = rem2;
         o.root = {s.root[30:0], 1'b0};
      end
      o.rad = {s.rad[61:0], 2'b00};
      return o;
   endfunction

   sq_type          sq_ff [SQ_N];
   logic [SQ_N-1:0] sq_vld_ff;

   // Division setup: denominator, rounded numerators, overflow check and the norm result.
   dv_type dp_in, dp_ff;
   logic   dp_vld_ff;
   logic [63:0] num [4];
   logic [31:0] root_w;

   always_comb begin
      dp_in   = '0;
      dp_in.c = sq_ff[SQ_N-1].c;
      root_w  = sq_ff[SQ_N-1].root;
      dp_in.den = (dp_in.c.action == ACT_INVERSE) ? dp_in.c.n2 : {32'b0, root_w};
      for (int i = 0; i < 4; i++) begin
         num[i] = ({32'b0, dp_in.c.mag[i]} << FRAC_BITS) + {1'b0, dp_in.den[63:1]};
         dp_in.ovf[i] = ({32'b0, num[i][63:32]} >= dp_in.den);
         dp_in.rr[i]  = {34'b0, num[i][63:32]};
         dp_in.nlo[i] = num[i][31:0];
      end
      if (dp_in.c.action == ACT_NORM) begin
         dp_in.c.res[0] = root_w[31] ? WORD_MAX : root_w;
         dp_in.c.st     = root_w[31] ? ST_SAT : ST_OK;
      end
   end

   // Restoring division, one quotient bit per stage in each lane.
   function automatic dv_type dv_step(input dv_type s);
      dv_type      o;
      logic [65:0] r2;
      o = s;
      for (int i = 0; i < 4; i++) begin
         r2 = {s.rr[i][64:0], s.nlo[i][31]};
         if (r2 >= {2'b00, s.den}) begin
            o.rr[i] = r2 - {2'b00, s.den};
            o.q[i]  = {s.q[i][30:0], 1'b1};
         end else begin
            o.rr[i] = r2;
            o.q[i]  = {s.q[i][30:0], 1'b0};
         end
         o.nlo[i] = {s.nlo[i][30:0], 1'b0};
      end
      return o;
   endfunction

   dv_type          dv_ff [DV_N];
   logic [DV_N-1:0] dv_vld_ff;

   // Final sign, saturation and status for normalize and inverse.
   carry_type fin_in;
   dv_type    dv_last;
   logic      big;
   logic      hitf;

   always_comb begin
      dv_last = dv_ff[DV_N-1];
      fin_in  = dv_last.c;
      hitf    = 1'b0;
      big     = 1'b0;
      if (fin_in.action == ACT_NORMALIZE || fin_in.action == ACT_INVERSE) begin
         for (int i = 0; i < 4; i++) begin
            if (fin_in.action == ACT_INVERSE && fin_in.n2zero) begin
               big = (fin_in.mag[i] != '0);
               fin_in.res[i] = big ? (fin_in.neg[i] ? WORD_MIN : WORD_MAX) : '0;
            end else begin
               big = dv_last.ovf[i] ||
                     (fin_in.neg[i] ? (dv_last.q[i] > 32'h80000000) : dv_last.q[i][31]);
               if (big) begin
                  fin_in.res[i] = fin_in.neg[i] ? WORD_MIN : WORD_MAX;
               end else begin
                  fin_in.res[i] = fin_in.neg[i] ? (~dv_last.q[i] + 32'd1) : dv_last.q[i];
               end
            end
            hitf = hitf | big;
         end
         if (fin_in.szero) begin
            fin_in.res = '0;
            fin_in.st  = ST_DIV0;
         end else begin
            fin_in.st  = hitf ? ST_SAT : ST_OK;
         end
      end
   end

   // Output register and matrix row sequencing.
   carry_type  ob_ff;
   logic       ob_vld_ff;
   logic [1:0] row_ff;
   logic       is_mat;
   logic       last_w;
   logic       pop;
   logic       done;

   always_comb begin
      is_mat = (ob_ff.action == ACT_MATRIX);
      last_w = !is_mat || (row_ff == 2'd2);
      pop    = ob_vld_ff && rsp_chan.ready;
      done   = pop && last_w;
      adv    = !ob_vld_ff || done;
      req_chan.ready = adv;
      rsp_chan.valid = ob_vld_ff;
      rsp_chan.last  = last_w;
      if (is_mat) begin
         rsp_chan.out_w = '0;
         case (row_ff)
            2'd0: begin
               rsp_chan.out_x  = ob_ff.mat[0];
               rsp_chan.out_y  = ob_ff.mat[1];
               rsp_chan.out_z  = ob_ff.mat[2];
               rsp_chan.status = ob_ff.mflag[0] ? ST_SAT : ST_OK;
            end
            2'd1: begin
               rsp_chan.out_x  = ob_ff.mat[3];
               rsp_chan.out_y  = ob_ff.mat[4];
               rsp_chan.out_z  = ob_ff.mat[5];
               rsp_chan.status = ob_ff.mflag[1] ? ST_SAT : ST_OK;
            end
            default: begin
               rsp_chan.out_x  = ob_ff.mat[6];
               rsp_chan.out_y  = ob_ff.mat[7];
               rsp_chan.out_z  = ob_ff.mat[8];
               rsp_chan.status = ob_ff.mflag[2] ? ST_SAT : ST_OK;
            end
         endcase
      end else begin
         rsp_chan.out_w  = ob_ff.res[0];
         rsp_chan.out_x  = ob_ff.res[1];
         rsp_chan.out_y  = ob_ff.res[2];
         rsp_chan.out_z  = ob_ff.res[3];
         rsp_chan.status = ob_ff.st;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         sq_ff[0] <= sq_step(s3_ff);
         for (int k = 1; k < SQ_N; k++) begin
            sq_ff[k] <= sq_step(sq_ff[k-1]);
         end
         dp_ff <= dp_in;
         dv_ff[0] <= dv_step(dp_ff);
         for (int k = 1; k < DV_N; k++) begin
            dv_ff[k] <= dv_step(dv_ff[k-1]);
         end
         ob_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         sq_vld_ff <= '0;
         dp_vld_ff <= 1'b0;
         dv_vld_ff <= '0;
         ob_vld_ff <= 1'b0;
         row_ff    <= '0;
      end else if (adv) begin
         s1_vld_ff <= req_chan.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         sq_vld_ff <= {sq_vld_ff[SQ_N-2:0], s3_vld_ff};
         dp_vld_ff <= sq_vld_ff[SQ_N-1];
         dv_vld_ff <= {dv_vld_ff[DV_N-2:0], dp_vld_ff};
         ob_vld_ff <= dv_vld_ff[DV_N-1];
         row_ff    <= '0;
      end else if (pop) begin
         row_ff <= row_ff + 2'd1;
      end
   end

   a_last_only_matrix: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last |-> ob_ff.action == ACT_MATRIX)
      else $error("non-final beat from a non-matrix item");

   a_div0_action: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_DIV0 |->
         (ob_ff.action == ACT_NORMALIZE || ob_ff.action == ACT_INVERSE))
      else $error("divide-by-zero status from an action without a division");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      ob_vld_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input accepted while the output register is stalled");

   a_row_single: assert property (@(posedge clock) disable iff (reset)
      ob_vld_ff && ob_ff.action != ACT_MATRIX |-> row_ff == 2'd0)
      else $error("row counter moved on a single-beat item");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      done && !dv_vld_ff[DV_N-1] |=> !ob_vld_ff)
      else $error("output register kept a beat that was already sent");

endmodule

`default_nettype wire

### sim/quaternion_arithmetic_unit_checker.sv
`default_nettype none

module quaternion_arithmetic_unit_checker import qau_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   qau_req_if.sink        req_mon,
   qau_rsp_if.sink        rsp_mon,
   output int unsigned    error_count,
   output int unsigned    rows_pending
);

   localparam int FB = FRAC_BITS_DEF;

   typedef struct {
      logic signed [31:0] w;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [1:0]         status;
      logic               last;
   } row_type;

   row_type expected_rows[$];

   function automatic logic signed [127:0] fx_mul(input logic signed [127:0] p,
                                                   input logic signed [127:0] q);
      logic signed [127:0] prod;
      prod = p * q + (128'sd1 <<< (FB - 1));
      return prod >>> FB;
   endfunction

   function automatic logic signed [127:0] clamp(input logic signed [127:0] v,
                                                  inout logic hit);
      logic signed [127:0] r;
      r = v;
      if (v > 128'sd2147483647) begin
         r = 128'sd2147483647;
         hit = 1'b1;
      end else if (v < -128'sd2147483648) begin
         r = -128'sd2147483648;
         hit = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [127:0] div_away(input logic signed [127:0] num,
                                                     input logic [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [127:0] root_floor(input logic [127:0] v);
      logic [127:0] r;
      logic [127:0] bitv;
      r = 0;
      bitv = 128'd1 << 64;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   task automatic predict_item();
      logic signed [127:0] a[4];
      logic signed [127:0] b[4];
      logic signed [127:0] r[4];
      logic signed [127:0] m[9];
      logic signed [127:0] cval;
      logic signed [127:0] xx, yy, zz, xy, xz, yz, xs, ys, zs;
      logic [127:0]        ssq;
      logic [127:0]        n;
      logic                hit;
      logic                rhit;
      logic [1:0]          st;
      row_type             row;
      a[0] = 128'(req_mon.a_w); a[1] = 128'(req_mon.a_x);
      a[2] = 128'(req_mon.a_y); a[3] = 128'(req_mon.a_z);
      b[0] = 128'(req_mon.b_w); b[1] = 128'(req_mon.b_x);
      b[2] = 128'(req_mon.b_y); b[3] = 128'(req_mon.b_z);
      cval = 128'(req_mon.scale);
      for (int i = 0; i < 4; i++) r[i] = 0;
      hit = 1'b0;
      st = ST_OK;
      ssq = 0;
      for (int i = 0; i < 4; i++) ssq = ssq + a[i] * a[i];
      if (ssq > 128'hFFFF_FFFF_FFFF_FFFF) ssq = 128'hFFFF_FFFF_FFFF_FFFF;
      case (req_mon.action)
         ACT_ADD: begin
            for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i], hit);
         end
         ACT_SUB: begin
            for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i], hit);
         end
         ACT_SCALE: begin
            for (int i = 0; i < 4; i++) r[i] = clamp(fx_mul(a[i], cval), hit);
         end
         ACT_MUL: begin
            r[0] = clamp(fx_mul(a[0], b[0]) - fx_mul(a[1], b[1]) - fx_mul(a[2], b[2])
                         - fx_mul(a[3], b[3]), hit);
            r[1] = clamp(fx_mul(a[0], b[1]) + fx_mul(b[0], a[1]) + fx_mul(a[2], b[3])
                         - fx_mul(a[3], b[2]), hit);
            r[2] = clamp(fx_mul(a[0], b[2]) + fx_mul(b[0], a[2]) + fx_mul(a[3], b[1])
                         - fx_mul(a[1], b[3]), hit);
            r[3] = clamp(fx_mul(a[0], b[3]) + fx_mul(b[0], a[3]) + fx_mul(a[1], b[2])
                         - fx_mul(a[2], b[1]), hit);
         end
         ACT_CONJ: begin
            r[0] = a[0];
            for (int i = 1; i < 4; i++) r[i] = clamp(-a[i], hit);
         end
         ACT_NORM: begin
            r[0] = clamp($signed(root_floor(ssq)), hit);
         end
         ACT_NORMALIZE: begin
            n = root_floor(ssq);
            if (n == 0) begin
               st = ST_DIV0;
            end else begin
               for (int i = 0; i < 4; i++) r[i] = clamp(div_away(a[i] <<< FB, n), hit);
            end
         end
         ACT_INVERSE: begin
            n = ssq >> FB;
            if (ssq == 0) begin
               st = ST_DIV0;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  cval = (i == 0) ? a[i] : -a[i];
                  if (n == 0) begin
                     if (cval > 0) r[i] = 128'sd2147483647;
                     else if (cval < 0) r[i] = -128'sd2147483648;
                     if (cval != 0) hit = 1'b1;
                  end else begin
                     r[i] = clamp(div_away(cval <<< FB, n), hit);
                  end
               end
            end
         end
         ACT_MATRIX: begin
            xx = fx_mul(a[1], a[1]); yy = fx_mul(a[2], a[2]); zz = fx_mul(a[3], a[3]);
            xy = fx_mul(a[1], a[2]); xz = fx_mul(a[1], a[3]); yz = fx_mul(a[2], a[3]);
            xs = fx_mul(a[1], a[0]); ys = fx_mul(a[2], a[0]); zs = fx_mul(a[3], a[0]);
            m[0] = (128'sd1 <<< FB) - 2 * yy - 2 * zz;
            m[1] = 2 * (xy - zs);
            m[2] = 2 * (xz + ys);
            m[3] = 2 * (xy + zs);
            m[4] = (128'sd1 <<< FB) - 2 * xx - 2 * zz;
            m[5] = 2 * (yz - xs);
            m[6] = 2 * (xz - ys);
            m[7] = 2 * (yz + xs);
            m[8] = (128'sd1 <<< FB) - 2 * xx - 2 * yy;
            for (int k = 0; k < 3; k++) begin
               rhit = 1'b0;
               row.w = '0;
               row.x = 32'(clamp(m[3 * k], rhit));
               row.y = 32'(clamp(m[3 * k + 1], rhit));
               row.z = 32'(clamp(m[3 * k + 2], rhit));
               row.status = rhit ? ST_SAT : ST_OK;
               row.last = (k == 2);
               expected_rows.push_back(row);
            end
            return;
         end
         default: begin
         end
      endcase
      if (st == ST_OK && hit) st = ST_SAT;
      row.w = 32'(r[0]); row.x = 32'(r[1]); row.y = 32'(r[2]); row.z = 32'(r[3]);
      row.status = st;
      row.last = 1'b1;
      expected_rows.push_back(row);
   endtask

   task automatic check_row();
      row_type want;
      if (expected_rows.size() == 0) begin
         $display("%0t: unexpected beat w=%h x=%h y=%h z=%h status=%0d last=%0b", $time,
                  rsp_mon.out_w, rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z,
                  rsp_mon.status, rsp_mon.last);
         error_count++;
         return;
      end
      want = expected_rows.pop_front();
      if (rsp_mon.out_w !== want.w || rsp_mon.out_x !== want.x || rsp_mon.out_y !== want.y
          || rsp_mon.out_z !== want.z || rsp_mon.status !== want.status
          || rsp_mon.last !== want.last) begin
         $display("%0t: expected w=%h x=%h y=%h z=%h status=%0d last=%0b", $time,
                  want.w, want.x, want.y, want.z, want.status, want.last);
         $display("%0t: actual   w=%h x=%h y=%h z=%h status=%0d last=%0b", $time,
                  rsp_mon.out_w, rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z,
                  rsp_mon.status, rsp_mon.last);
         error_count++;
      end
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) check_row();
         if (req_mon.valid && req_mon.ready) predict_item();
      end
      rows_pending <= expected_rows.size();
   end

endmodule

`default_nettype wire

### sim/quaternion_arithmetic_unit_core_tb.sv
`default_nettype none

module quaternion_arithmetic_unit_core_tb;
   import qau_pkg::*;

   localparam int ITEM_TOTAL = 260;
   localparam int CALM_TAIL = 40;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned error_count;
   int unsigned rows_pending;
   int unsigned cycle_count = 0;
   int          sent = 0;
   logic        tail_calm = 1'b0;

   qau_req_if req_chan ();
   qau_rsp_if rsp_chan ();

   quaternion_arithmetic_unit_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   quaternion_arithmetic_unit_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan.sink),
      .rsp_mon      (rsp_chan.sink),
      .error_count  (error_count),
      .rows_pending (rows_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver stalls come in bursts and stop once the calm tail begins.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || tail_calm) begin
         rsp_chan.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return 0;
         3: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
         4: return $signed($urandom_range(0, 32'h200)) - 32'sh100;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic [3:0] act, input word_type aw, input word_type ax,
                            input word_type ay, input word_type az, input word_type bw,
                            input word_type bx, input word_type by, input word_type bz,
                            input word_type sc);
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.a_w <= aw; req_chan.a_x <= ax; req_chan.a_y <= ay; req_chan.a_z <= az;
      req_chan.b_w <= bw; req_chan.b_x <= bx; req_chan.b_y <= by; req_chan.b_z <= bz;
      req_chan.scale <= sc;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      if (!tail_calm && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [3:0] act;
      word_type   q[4];
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
      if ($urandom_range(0, 1)) begin
         for (int i = 0; i < 4; i++) q[i] = pick_word();
      end else begin
         for (int i = 0; i < 4; i++) q[i] = $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
      end
      send_item(act, q[0], q[1], q[2], q[3], pick_word(), pick_word(), pick_word(),
                pick_word(), pick_word());
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.action = ACT_ADD;
      req_chan.a_w = 0; req_chan.a_x = 0; req_chan.a_y = 0; req_chan.a_z = 0;
      req_chan.b_w = 0; req_chan.b_x = 0; req_chan.b_y = 0; req_chan.b_z = 0;
      req_chan.scale = 0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_ADD, WORD_MAX, WORD_MIN, 1, -1, 1, -1, WORD_MIN, 0, 0);
      send_item(ACT_SUB, WORD_MIN, WORD_MAX, 0, -1, 1, -1, 0, WORD_MIN, 0);
      send_item(ACT_SCALE, WORD_MAX, WORD_MIN, 32'sh8000, -32'sh8000, 0, 0, 0, 0, WORD_MIN);
      send_item(ACT_SCALE, 32'sh1_8000, -3, 3, 1, 0, 0, 0, 0, 32'sh8000);
      send_item(ACT_MUL, 32'sh1_0000, 32'sh2_0000, -32'sh1_0000, 32'sh8000,
                32'sh1_0000, -32'sh1_0000, 32'sh3_0000, 5, 0);
      send_item(ACT_MUL, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 0);
      send_item(ACT_CONJ, WORD_MIN, WORD_MIN, WORD_MAX, 0, 0, 0, 0, 0, 0);
      send_item(ACT_NORM, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0, 0);
      send_item(ACT_NORM, 32'sh3_0000, 32'sh4_0000, 0, 0, 0, 0, 0, 0, 0);
      send_item(ACT_NORMALIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(ACT_NORMALIZE, 1, 0, 0, -1, 0, 0, 0, 0, 0);
      send_item(ACT_NORMALIZE, WORD_MIN, WORD_MAX, 7, -7, 0, 0, 0, 0, 0);
      send_item(ACT_INVERSE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(ACT_INVERSE, 1, -1, 0, 2, 0, 0, 0, 0, 0);
      send_item(ACT_INVERSE, 32'sh2_0000, 32'sh1_0000, -32'sh1_0000, 0, 0, 0, 0, 0, 0);
      send_item(ACT_INVERSE, 32'sh100, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(ACT_MATRIX, 32'sh1_0000, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(ACT_MATRIX, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 0, 0, 0, 0, 0);
      send_item(4'd9, 5, 5, 5, 5, 5, 5, 5, 5, 5);
      send_item(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1);

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (rows_pending != 0);

      while (sent < ITEM_TOTAL) begin
         if (sent >= ITEM_TOTAL - CALM_TAIL) tail_calm = 1'b1;
         send_random();
      end
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (rows_pending != 0);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
